// File: rtl/core/ifs_pkg.sv
package ifs_pkg;

  localparam int MAX_TREES_DEF      = 64;
  localparam int NODES_PER_TREE_DEF = 256;
  localparam int MAX_DEPTH_DEF      = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_TREE_COUNT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_NORM = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  localparam logic [1:0] CLASS_NORMAL  = 2'd0;
  localparam logic [1:0] CLASS_MILD    = 2'd1;
  localparam logic [1:0] CLASS_SUSPECT = 2'd2;
  localparam logic [1:0] CLASS_ANOMALY = 2'd3;

  // Q0.16 class boundaries: 0.5, 0.7, 0.8
  localparam logic [15:0] SCORE_HALF  = 16'd32768;
  localparam logic [15:0] SCORE_SEVEN = 16'd45875;
  localparam logic [15:0] SCORE_EIGHT = 16'd52428;

  localparam logic [63:0] LN2_Q16   = 64'd45426;
  localparam logic [63:0] GAMMA_Q16 = 64'd37829;

  typedef struct packed {
    logic [7:0]  child_below;
    logic [7:0]  child_above;
    logic        is_leaf;
    logic [7:0]  leaf_size;
    logic [31:0] threshold;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCORE,
    ST_HOLD
  } walk_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_EXP,
    SC_ROUND
  } score_state_t;

  // Elaboration-time helpers for the constant tables below.
  function automatic logic [63:0] ln_q16(logic [31:0] n);
    logic [63:0] y;
    logic [63:0] lg;
    int          k;
    k = 0;
    for (int j = 1; j < 32; j++) begin
      if ((n >> j) != 32'd0) k = j;
    end
    y  = ({32'd0, n} << 16) >> k;
    lg = 64'(k) << 16;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 16;
      if (y >= 64'd131072) begin
        y     = y >> 1;
        lg[i] = 1'b1;
      end
    end
    return (lg * LN2_Q16) >> 16;
  endfunction

  function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [15:0] c_q88(int m);
    logic [63:0] h;
    logic [63:0] t;
    logic [63:0] c;
    if (m <= 1) return 16'd0;
    if (m == 2) return 16'd256;
    h = ln_q16(32'(m - 1)) + GAMMA_Q16;
    t = long_div(64'(2 * (m - 1)) << 16, 64'(m));
    c = 2 * h - t;
    return 16'((c + 64'd128) >> 8);
  endfunction

  function automatic logic [255:0][15:0] build_c_table();
    logic [255:0][15:0] tab;
    for (int m = 0; m < 256; m++) tab[m] = c_q88(m);
    return tab;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    logic [63:0] rem;
    res   = '0;
    rem   = v;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Q.32 factors 2^(-2^-i), i = 1..16, entry i-1
  function automatic logic [15:0][31:0] build_exp_factors();
    logic [15:0][31:0] tab;
    logic [63:0]       f;
    f = 64'd1 << 31;
    for (int i = 0; i < 16; i++) begin
      f      = isqrt64(f << 32);
      tab[i] = f[31:0];
    end
    return tab;
  endfunction

  // c(leaf size) in Q8.8
  localparam logic [255:0][15:0] C_TABLE    = build_c_table();
  localparam logic [15:0][31:0]  EXP_FACTOR = build_exp_factors();

endpackage

// File: rtl/core/ifs_item_if.sv
interface ifs_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  tree_index;
  logic [7:0]  node_index;
  logic [7:0]  child_below;
  logic [7:0]  child_above;
  logic        is_leaf;
  logic [7:0]  leaf_size;
  logic [31:0] threshold;
  logic [31:0] sample_value;

  modport source (
    output valid, opcode, tree_index, node_index, child_below, child_above,
           is_leaf, leaf_size, threshold, sample_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, tree_index, node_index, child_below, child_above,
           is_leaf, leaf_size, threshold, sample_value,
    output ready
  );
endinterface

// File: rtl/core/ifs_result_if.sv
interface ifs_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] score;
  logic [1:0]  score_class;

  modport source (output valid, score, score_class, input ready);
  modport sink (input valid, score, score_class, output ready);
endinterface

// File: rtl/core/isolation_forest_scorer_core.sv
// Isolation forest scorer. Write beats (opcode 0) store one node in the node
// memory; writes with an out-of-range index are dropped. Score beats (opcode
// 1) walk trees 0..min(tree_count, MAX_TREES)-1 from node 0, one node read
// per cycle from the single read port of the node memory, then run a scoring
// unit (one multiply for x, sixteen multiply steps for 2^-frac, one rounding
// step) and load the output register; with no trees the score is zero. A walk
// visits at most MAX_DEPTH + 1 nodes per tree.
// Beats are accepted only between items; a finished score waits in the output
// register without blocking the next beat. Node memory contents are undefined
// after reset and every node a walk can reach must be written first.
module isolation_forest_scorer_core #(
  parameter int MAX_TREES      = ifs_pkg::MAX_TREES_DEF,
  parameter int NODES_PER_TREE = ifs_pkg::NODES_PER_TREE_DEF,
  parameter int MAX_DEPTH      = ifs_pkg::MAX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [ifs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ifs_pkg::CFG_DATA_W-1:0]  cfg_data,
  ifs_item_if.sink                        item,
  ifs_result_if.source                    result
);

  import ifs_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_TREES * NODES_PER_TREE);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W   = $clog2(MAX_TREES + 1);
  localparam int TOTAL_W = $clog2(MAX_TREES * (MAX_DEPTH * 256 + 65536));

  walk_state_t state, state_next;

  logic [6:0]          tree_count;
  logic [23:0]         inverse_norm;
  logic [CNT_W-1:0]    n_trees;
  logic [CNT_W-1:0]    tree;
  logic [DEPTH_W-1:0]  depth;
  logic [ADDR_W-1:0]   tree_base;
  logic [31:0]         sample;
  logic [TOTAL_W-1:0]  total;
  logic                zero_result;

  logic                out_valid;
  logic [15:0]         out_score;
  logic [1:0]          out_class;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  node_t               ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [NODE_W-1:0]   ram_rdata;

  node_t               node;
  logic [CNT_W-1:0]    n_eff;
  logic                take;
  logic                wr_ok;
  logic [7:0]          child;
  logic                child_ok;
  logic                at_limit;
  logic                walk_done;
  logic                last_tree;
  logic [TOTAL_W-1:0]  depth_q88;
  logic [TOTAL_W-1:0]  walk_add;
  logic [TOTAL_W-1:0]  total_sum;
  logic [ADDR_W-1:0]   base_next;
  logic                out_free;

  logic                score_start;
  logic                score_done;
  logic [15:0]         unit_score;
  logic [1:0]          unit_class;

  assign take     = item.valid && item.ready;
  assign n_eff    = (32'(tree_count) > MAX_TREES) ? CNT_W'(MAX_TREES) : CNT_W'(tree_count);
  assign wr_ok    = (32'(item.tree_index) < MAX_TREES) && (32'(item.node_index) < NODES_PER_TREE);
  assign out_free = !out_valid || result.ready;

  // node write path
  assign ram_we    = take && (item.opcode == OP_WRITE) && wr_ok;
  assign ram_waddr = ADDR_W'(32'(item.tree_index) * NODES_PER_TREE + 32'(item.node_index));
  assign ram_wdata = '{child_below: item.child_below,
                       child_above: item.child_above,
                       is_leaf:     item.is_leaf,
                       leaf_size:   item.leaf_size,
                       threshold:   item.threshold};

  // walk step on the node read back this cycle
  assign node      = node_t'(ram_rdata);
  assign child     = (sample < node.threshold) ? node.child_below : node.child_above;
  assign child_ok  = 32'(child) < NODES_PER_TREE;
  assign at_limit  = 32'(depth) == MAX_DEPTH;
  assign walk_done = node.is_leaf || at_limit || !child_ok;
  assign last_tree = tree == n_trees - CNT_W'(1);
  assign depth_q88 = TOTAL_W'({depth, 8'd0});
  assign base_next = ADDR_W'(32'(tree_base) + NODES_PER_TREE);
  assign total_sum = total + walk_add;

  always_comb begin
    if (node.is_leaf)  walk_add = depth_q88 + TOTAL_W'(C_TABLE[node.leaf_size]);
    else if (at_limit) walk_add = depth_q88;
    else               walk_add = depth_q88 + TOTAL_W'(9'd256);
  end

  assign item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    ram_raddr   = '0;
    score_start = 1'b0;
    case (state)
      ST_IDLE: begin
        // root of tree 0 is read while idle
        if (take && item.opcode == OP_SCORE) begin
          state_next = (n_eff == '0) ? ST_HOLD : ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_done) begin
          ram_raddr = tree_base + ADDR_W'(child);
        end else if (last_tree) begin
          score_start = 1'b1;
          state_next  = ST_SCORE;
        end else begin
          ram_raddr = base_next;
        end
      end
      ST_SCORE: if (score_done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_count   <= 7'd1;
      inverse_norm <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_TREE_COUNT:   tree_count   <= cfg_data[6:0];
          CFG_INVERSE_NORM: inverse_norm <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_HOLD && out_free) out_valid <= 1'b1;
      else if (result.ready)            out_valid <= 1'b0;
    end

    if (state == ST_HOLD && out_free) begin
      out_score <= zero_result ? '0 : unit_score;
      out_class <= zero_result ? CLASS_NORMAL : unit_class;
    end

    if (take && item.opcode == OP_SCORE) begin
      sample      <= item.sample_value;
      n_trees     <= n_eff;
      zero_result <= (n_eff == '0);
      tree        <= '0;
      depth       <= '0;
      tree_base   <= '0;
      total       <= '0;
    end else if (state == ST_WALK) begin
      if (!walk_done) begin
        depth <= depth + DEPTH_W'(1);
      end else begin
        total     <= total_sum;
        tree      <= tree + CNT_W'(1);
        depth     <= '0;
        tree_base <= base_next;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.score       = out_score;
  assign result.score_class = out_class;

  ifs_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_TREES * NODES_PER_TREE)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ifs_score #(
    .TOTAL_W (TOTAL_W)
  ) u_score (
    .clk          (clk),
    .rst          (rst),
    .start        (score_start),
    .total        (total_sum),
    .inverse_norm (inverse_norm),
    .done         (score_done),
    .score        (unit_score),
    .score_class  (unit_class)
  );

  a_tree_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> tree < n_trees)
    else $error("walk past last tree");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    score_done |-> state == ST_SCORE)
    else $error("score unit finished outside scoring state");

  a_class_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_class == CLASS_NORMAL) == (out_score <= SCORE_HALF)) &&
                  ((out_class == CLASS_ANOMALY) == (out_score > SCORE_EIGHT)))
    else $error("score class does not match score");

endmodule

// File: rtl/core/ifs_ram.sv
module ifs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ifs_score.sv
module ifs_score #(
  parameter int TOTAL_W = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TOTAL_W-1:0] total,
  input  logic [23:0]        inverse_norm,
  output logic               done,
  output logic [15:0]        score,
  output logic [1:0]         score_class
);

  import ifs_pkg::*;

  localparam int X_W  = TOTAL_W + 24;
  localparam int XI_W = X_W - 32;

  score_state_t st, st_next;

  logic [TOTAL_W-1:0] total_r;
  logic [XI_W-1:0]    x_int;
  logic [15:0]        frac;
  logic [32:0]        res;
  logic [3:0]         step;

  logic [X_W-1:0]  x;
  logic [64:0]     prod;
  logic [32:0]     shifted;
  logic [33:0]     rnd;
  logic [17:0]     v;
  logic [15:0]     score_val;
  logic [1:0]      class_val;

  assign x    = X_W'(total_r) * X_W'(inverse_norm);
  assign prod = 65'(res) * 65'(EXP_FACTOR[step]);

  always_comb begin
    shifted = res >> x_int[5:0];
    rnd     = 34'(shifted) + 34'd32768;
    v       = rnd[33:16];
    if (x_int >= XI_W'(33))      score_val = '0;
    else if (v > 18'd65535)      score_val = 16'hFFFF;
    else                         score_val = v[15:0];
    if (score_val <= SCORE_HALF)       class_val = CLASS_NORMAL;
    else if (score_val <= SCORE_SEVEN) class_val = CLASS_MILD;
    else if (score_val <= SCORE_EIGHT) class_val = CLASS_SUSPECT;
    else                               class_val = CLASS_ANOMALY;
  end

  always_ff @(posedge clk) begin
    if (rst) st <= SC_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    st_next = st;
    case (st)
      SC_IDLE:  if (start) st_next = SC_MUL;
      SC_MUL:   st_next = SC_EXP;
      SC_EXP:   if (step == 4'd15) st_next = SC_ROUND;
      SC_ROUND: st_next = SC_IDLE;
      default:  st_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (st == SC_ROUND);
    end
    case (st)
      SC_IDLE: if (start) total_r <= total;
      SC_MUL: begin
        x_int <= x[X_W-1:32];
        frac  <= x[31:16];
        res   <= 33'd1 << 32;
        step  <= '0;
      end
      SC_EXP: begin
        // one square-root factor per fraction bit, msb first
        if (frac[4'd15 - step]) res <= prod[64:32];
        step <= step + 4'd1;
      end
      SC_ROUND: begin
        score       <= score_val;
        score_class <= class_val;
      end
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> st == SC_IDLE)
    else $error("score start while busy");

  a_done_after_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(st) == SC_ROUND)
    else $error("score done without rounding step");

endmodule
